FILE: rtl/core/rbd_pkg.sv
// Shared types and constants for the ring buffer deque.
// No dependencies; used by rbd_ctrl and ring_buffer_deque_unit.
package rbd_pkg;

	localparam int unsigned MSG_W   = 64;
	localparam int unsigned SLOTS_W = 5;

	typedef enum logic [1:0] {
		MODE_PUSH_REAR  = 2'd0,
		MODE_PUSH_FRONT = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_CLEAR      = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [MSG_W-1:0]   message_in;
	} cmd_word_t;

	typedef struct packed {
		logic               success;
		logic [MSG_W-1:0]   message_out;
		logic               is_empty;
		logic               is_full;
		logic [SLOTS_W-1:0] free_slots;
	} res_word_t;

	// status of one operation, held in stage 1 until the result word leaves
	typedef struct packed {
		logic               success;
		logic               pop_ok;
		logic               is_empty;
		logic               is_full;
		logic [SLOTS_W-1:0] free_slots;
	} stat_t;

endpackage

FILE: rtl/core/ring_buffer_deque_unit.sv
// Top level of the ring buffer deque: control, slot RAM and result stage.
// Depends on rbd_pkg, rbd_ram and rbd_ctrl.
//
//  channel | valid     | stall     | word
//  command | cmd_valid | cmd_stall | cmd (rbd_pkg::cmd_word_t)
//  result  | res_valid | res_stall | res (rbd_pkg::res_word_t)
//
// One command is taken per cycle while cmd_stall is low; its result word
// appears the next cycle. Pointers and free count update at acceptance;
// a pop reads the slot RAM at the same edge and its registered read data
// feeds the result word. While a result waits under res_stall, cmd_stall
// is high, which keeps the RAM read data stable. Reset empties the buffer
// at once; the slot contents are not cleared.
module ring_buffer_deque_unit #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  rbd_pkg::cmd_word_t  cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output rbd_pkg::res_word_t  res
);

	localparam int unsigned IW = $clog2(DEPTH);

	logic                  go, take, we, re;
	logic [IW-1:0]         waddr, raddr;
	logic [DATA_WIDTH-1:0] rdata;
	rbd_pkg::stat_t        stat_s1;

	assign cmd_stall = res_valid && res_stall;
	assign go        = cmd_valid && !cmd_stall;
	assign take      = res_valid && !res_stall;

	rbd_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.mode     (cmd.mode),
		.take     (take),
		.we       (we),
		.waddr    (waddr),
		.re       (re),
		.raddr    (raddr),
		.valid_s1 (res_valid),
		.stat_s1  (stat_s1)
	);

	rbd_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cmd.message_in[DATA_WIDTH-1:0]),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// zero the message unless this word is a successful pop
	always_comb begin
		res.success     = stat_s1.success;
		res.message_out = stat_s1.pop_ok ? rbd_pkg::MSG_W'(rdata) : '0;
		res.is_empty    = stat_s1.is_empty;
		res.is_full     = stat_s1.is_full;
		res.free_slots  = stat_s1.free_slots;
	end

`ifndef ASSERT_OFF
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> res_valid)
		else $error("accepted command produced no result word");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_empty |-> res.free_slots == rbd_pkg::SLOTS_W'(DEPTH))
		else $error("empty buffer with wrong free count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_full |-> res.free_slots == rbd_pkg::SLOTS_W'(1))
		else $error("full buffer with wrong free count");

	a_msg_only_on_success: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.success |-> res.message_out == '0)
		else $error("failed operation returned a message");
`endif

endmodule

FILE: rtl/core/rbd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module rbd_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/rbd_ctrl.sv
// Pointer and free-count control of the ring buffer deque; drives the slot RAM
// ports and holds the stage-1 status. Depends on rbd_pkg.
module rbd_ctrl #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  rbd_pkg::mode_t           mode,
	input  logic                     take,
	output logic                     we,
	output logic [$clog2(DEPTH)-1:0] waddr,
	output logic                     re,
	output logic [$clog2(DEPTH)-1:0] raddr,
	output logic                     valid_s1,
	output rbd_pkg::stat_t           stat_s1
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	logic [IW-1:0] front_q, rear_q, front_n, rear_n;
	logic [IW-1:0] front_inc, front_dec, rear_inc, rear_n_inc;
	logic [CW-1:0] free_q, free_n;
	logic          full, empty, ok, pop_ok;

	assign front_inc  = (front_q == LAST) ? '0 : front_q + 1'b1;
	assign front_dec  = (front_q == '0) ? LAST : front_q - 1'b1;
	assign rear_inc   = (rear_q == LAST) ? '0 : rear_q + 1'b1;
	assign full       = (rear_inc == front_q);
	assign empty      = (front_q == rear_q);

	always_comb begin
		front_n = front_q;
		rear_n  = rear_q;
		free_n  = free_q;
		ok      = 1'b0;
		pop_ok  = 1'b0;
		we      = 1'b0;
		waddr   = rear_inc;
		re      = 1'b0;
		raddr   = front_inc;
		unique case (mode)
			rbd_pkg::MODE_PUSH_REAR: begin
				if (!full) begin
					ok     = 1'b1;
					we     = go;
					rear_n = rear_inc;
					free_n = free_q - 1'b1;
				end
			end
			rbd_pkg::MODE_PUSH_FRONT: begin
				if (!full) begin
					ok      = 1'b1;
					we      = go;
					waddr   = front_q;
					front_n = front_dec;
					free_n  = free_q - 1'b1;
				end
			end
			rbd_pkg::MODE_POP_FRONT: begin
				if (!empty) begin
					ok      = 1'b1;
					pop_ok  = 1'b1;
					re      = go;
					front_n = front_inc;
					free_n  = free_q + 1'b1;
				end
			end
			rbd_pkg::MODE_CLEAR: begin
				ok      = 1'b1;
				front_n = '0;
				rear_n  = '0;
				free_n  = CW'(DEPTH);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign rear_n_inc = (rear_n == LAST) ? '0 : rear_n + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			rear_q   <= '0;
			free_q   <= CW'(DEPTH);
			valid_s1 <= 1'b0;
		end else begin
			if (go) begin
				front_q  <= front_n;
				rear_q   <= rear_n;
				free_q   <= free_n;
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			stat_s1.success    <= ok;
			stat_s1.pop_ok     <= pop_ok;
			stat_s1.is_empty   <= (front_n == rear_n);
			stat_s1.is_full    <= (rear_n_inc == front_n);
			stat_s1.free_slots <= rbd_pkg::SLOTS_W'(free_n);
		end
	end

endmodule
